>>> rtl/sm3_pkg.sv
// shared types, constants and round functions of the sm3 hash engine
package sm3_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_digest;
    } digest_beat_t;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_LAST_FULL = 2'd1,
        KIND_LAST_PART = 2'd2
    } entry_kind_t;

    typedef struct packed {
        logic [31:0] word;
        entry_kind_t kind;
        logic [5:0]  add_bits;
    } q_entry_t;

    typedef struct packed {
        logic start;
        logic rearm;
    } cmp_ctrl_t;

    typedef logic [15:0][31:0] block_t;
    typedef logic [7:0][31:0]  chain_t;

    localparam logic [31:0] T_LOW     = 32'h79cc4519;
    localparam logic [31:0] T_HIGH    = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [31:0] PAD_WORD  = {PAD_BYTE, 24'h000000};
    localparam int          PAD_LIMIT = 56;
    localparam logic [3:0]  LEN_SLOT  = 4'(PAD_LIMIT / 4);
    localparam logic [3:0]  LAST_SLOT = 4'd15;

    localparam chain_t SM3_IV = {
        32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
        32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
    };

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

endpackage

>>> rtl/sm3_front.sv
// front end: takes message beats, masks and pads a partial final word, tags each entry
module sm3_front
    import sm3_pkg::*;
(
    input  logic      msg_valid,
    input  msg_beat_t msg,
    output logic      msg_stall,
    input  logic      q_full,
    output logic      q_push,
    output q_entry_t  q_entry
);

    logic [2:0]  bc_sat;
    logic [5:0]  shift;
    logic [31:0] keep;
    logic [31:0] pad;

    always_comb
    begin
        bc_sat = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
        shift  = {bc_sat, 3'b000};
        keep   = ~(32'hffffffff >> shift);
        pad    = PAD_WORD >> shift;

        if (!msg.last_word)
        begin
            q_entry.word     = msg.data_word;
            q_entry.kind     = KIND_DATA;
            q_entry.add_bits = 6'd32;
        end
        else if (bc_sat == 3'd4)
        begin
            q_entry.word     = msg.data_word;
            q_entry.kind     = KIND_LAST_FULL;
            q_entry.add_bits = 6'd32;
        end
        else
        begin
            // unused bytes dropped, pad byte right after the last valid one
            q_entry.word     = (msg.data_word & keep) | pad;
            q_entry.kind     = KIND_LAST_PART;
            q_entry.add_bits = shift;
        end
    end

    assign msg_stall = q_full;
    assign q_push    = msg_valid && !q_full;

endmodule

>>> rtl/sm3_queue.sv
// small fifo of classified entries between front and back
module sm3_queue
    import sm3_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_data,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/sm3_compress.sv
// compression unit: one sm3 round per cycle, message expansion in a 16-word shift line
module sm3_round_core
    import sm3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmp_ctrl_t ctrl,
    input  block_t    block,
    output logic      busy,
    output chain_t    chain
);

    typedef enum logic [2:0] {
        CMP_IDLE  = 3'b001,
        CMP_ROUND = 3'b010,
        CMP_FOLD  = 3'b100
    } cmp_state_t;

    cmp_state_t  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [31:0] t_reg, t_next;
    chain_t      chain_reg, chain_next;
    chain_t      v_reg, v_next;
    block_t      w_reg, w_next;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
    chain_t      v_round;
    logic        early;

    assign busy  = (state_reg != CMP_IDLE);
    assign chain = chain_reg;

    always_comb
    begin
        early = (round_reg[5:4] == 2'b00);
        a12   = rol32(v_reg[0], 12);
        ss1   = rol32(a12 + v_reg[4] + t_reg, 7);
        ss2   = ss1 ^ a12;
        if (early)
        begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end
        else
        begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + v_reg[7] + ss1 + w_reg[0];

        v_round[0] = tt1;
        v_round[1] = v_reg[0];
        v_round[2] = rol32(v_reg[1], 9);
        v_round[3] = v_reg[2];
        v_round[4] = perm0(tt2);
        v_round[5] = v_reg[4];
        v_round[6] = rol32(v_reg[5], 19);
        v_round[7] = v_reg[6];

        // word j+16 of the expanded schedule
        w_new = perm1(w_reg[0] ^ w_reg[7] ^ rol32(w_reg[13], 15))
                ^ rol32(w_reg[3], 7) ^ w_reg[10];
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        t_next     = t_reg;
        chain_next = chain_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        unique case (state_reg)
            CMP_IDLE:
            begin
                if (ctrl.rearm)
                begin
                    chain_next = SM3_IV;
                end
                else if (ctrl.start)
                begin
                    w_next     = block;
                    v_next     = chain_reg;
                    t_next     = T_LOW;
                    round_next = '0;
                    state_next = CMP_ROUND;
                end
            end
            CMP_ROUND:
            begin
                v_next     = v_round;
                w_next     = {w_new, w_reg[15:1]};
                t_next     = (round_reg == 6'd15) ? rol32(T_HIGH, 16) : rol32(t_reg, 1);
                round_next = round_reg + 1'b1;
                if (round_reg == 6'd63)
                begin
                    state_next = CMP_FOLD;
                end
            end
            CMP_FOLD:
            begin
                chain_next = chain_reg ^ v_reg;
                state_next = CMP_IDLE;
            end
            default:
            begin
                state_next = CMP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CMP_IDLE;
            chain_reg <= SM3_IV;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        round_reg <= round_next;
        t_reg     <= t_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
    end

endmodule

>>> rtl/sm3_back.sv
// back end: block assembly, padding and length words, digest output register
module sm3_back
    import sm3_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  q_entry_t     q_entry,
    output logic         q_pop,
    output cmp_ctrl_t    cmp_ctrl,
    output block_t       cmp_block,
    input  logic         cmp_busy,
    input  chain_t       chain,
    output logic         digest_valid,
    output digest_beat_t digest,
    input  logic         digest_stall
);

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_PAD   = 7'b0000010,
        B_ZERO  = 7'b0000100,
        B_LENHI = 7'b0001000,
        B_LENLO = 7'b0010000,
        B_WAIT  = 7'b0100000,
        B_EMIT  = 7'b1000000
    } back_state_t;

    back_state_t  state_reg, state_next;
    logic [3:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [2:0]   idx_reg, idx_next;
    block_t       buf_reg;
    logic         out_valid_reg, out_valid_next;
    digest_beat_t out_reg, out_next;

    logic         push_req, push_ok, out_load;
    logic [31:0]  push_word;

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;
    assign out_load     = (state_reg == B_EMIT) && (!out_valid_reg || !digest_stall);

    always_comb
    begin
        push_req  = 1'b0;
        push_word = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                push_req  = !q_empty;
                push_word = q_entry.word;
            end
            B_PAD:
            begin
                push_req  = 1'b1;
                push_word = PAD_WORD;
            end
            B_ZERO:
            begin
                push_req  = (fill_reg != LEN_SLOT);
            end
            B_LENHI:
            begin
                push_req  = 1'b1;
                push_word = bits_reg[63:32];
            end
            B_LENLO:
            begin
                push_req  = 1'b1;
                push_word = bits_reg[31:0];
            end
            B_WAIT, B_EMIT:
            begin
                push_req  = 1'b0;
            end
            default:
            begin
                push_req  = 1'b0;
            end
        endcase

        // the word that completes a block waits for the compressor
        push_ok        = push_req && ((fill_reg != LAST_SLOT) || !cmp_busy);
        cmp_block      = buf_reg;
        cmp_block[15]  = push_word;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = push_ok ? fill_reg + 1'b1 : fill_reg;
        bits_next      = bits_reg;
        idx_next       = idx_reg;
        q_pop          = 1'b0;
        cmp_ctrl.start = push_ok && (fill_reg == LAST_SLOT);
        cmp_ctrl.rearm = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && digest_stall;
        unique case (state_reg)
            B_IDLE:
            begin
                if (push_ok)
                begin
                    q_pop     = 1'b1;
                    bits_next = bits_reg + {58'd0, q_entry.add_bits};
                    unique case (q_entry.kind)
                        KIND_DATA:      state_next = B_IDLE;
                        KIND_LAST_FULL: state_next = B_PAD;
                        KIND_LAST_PART: state_next = B_ZERO;
                        default:        state_next = B_IDLE;
                    endcase
                end
            end
            B_PAD:
            begin
                if (push_ok)
                begin
                    state_next = B_ZERO;
                end
            end
            B_ZERO:
            begin
                // zeros up to the length slot, through an extra block if needed
                if (fill_reg == LEN_SLOT)
                begin
                    state_next = B_LENHI;
                end
            end
            B_LENHI:
            begin
                if (push_ok)
                begin
                    state_next = B_LENLO;
                end
            end
            B_LENLO:
            begin
                if (push_ok)
                begin
                    state_next = B_WAIT;
                end
            end
            B_WAIT:
            begin
                if (!cmp_busy)
                begin
                    idx_next   = '0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next       = 1'b1;
                    out_next.digest_word = chain[idx_reg];
                    out_next.word_index  = idx_reg;
                    out_next.last_digest = (idx_reg == 3'd7);
                    idx_next             = idx_reg + 1'b1;
                    if (idx_reg == 3'd7)
                    begin
                        cmp_ctrl.rearm = 1'b1;
                        bits_next      = '0;
                        state_next     = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (push_ok)
        begin
            buf_reg[fill_reg] <= push_word;
        end
    end

endmodule

>>> rtl/sm3_hash_engine.sv
// sm3 hash engine top level: front end, entry queue, back end and compressor
//
// message beats come in on msg (msg_valid / msg_stall): 32-bit big-endian words,
// byte_count gives the valid leading bytes of the final word, last_word ends a message.
// each message yields eight digest beats on digest (digest_valid / digest_stall),
// word_index 0 first, last_digest set on the eighth.
// a 16-word block keeps the compressor busy for its 64 rounds, one per cycle, and the
// chaining fold, and the next block can start once the compressor is idle again;
// the next block fills while the current one is compressed.
// after the final word the back end writes the padding and length words, the word that
// completes a block waiting for the compressor, waits for the last one or two compressions
// and then loads one digest beat per cycle into the output register while not stalled.
// the entry queue (QUEUE_DEPTH entries) lets the input keep flowing while the back end
// waits on the compressor or on a stalled receiver; msg_stall rises only when it is full.
// a stalled digest beat holds in the output register and emission pauses.
// reset clears the queue, the length counter and the block fill, and loads the iv;
// after the last digest beat the engine re-arms with the iv by itself.
module sm3_hash_engine
    import sm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    input  msg_beat_t    msg,
    output logic         msg_stall,
    output logic         digest_valid,
    output digest_beat_t digest,
    input  logic         digest_stall
);

    logic      q_push, q_full, q_pop, q_empty;
    q_entry_t  q_in, q_out;
    cmp_ctrl_t cmp_ctrl;
    block_t    cmp_block;
    logic      cmp_busy;
    chain_t    chain;

    sm3_front u_front (
        .msg_valid (msg_valid),
        .msg       (msg),
        .msg_stall (msg_stall),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    sm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    sm3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_entry      (q_out),
        .q_pop        (q_pop),
        .cmp_ctrl     (cmp_ctrl),
        .cmp_block    (cmp_block),
        .cmp_busy     (cmp_busy),
        .chain        (chain),
        .digest_valid (digest_valid),
        .digest       (digest),
        .digest_stall (digest_stall)
    );

    sm3_round_core u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cmp_ctrl),
        .block (cmp_block),
        .busy  (cmp_busy),
        .chain (chain)
    );

endmodule
